// File: hdl/spica_pkg.sv
// Shared types and constants for the SPI command/ACK transaction master.
// No dependencies; imported by every module of the block.
package spica_pkg;

  localparam int MAX_REPLY    = 32;
  localparam int STRING_LIMIT = 25;
  localparam int CNT_W        = 6;
  localparam int CFG_IDX_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 4'd1;

  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] SETTLE_RST      = 16'd100;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_BYTE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_REPLY = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_WAIT_HIGH   = 3'd1,
    PH_WAIT_LOW    = 3'd2,
    PH_SETTLE      = 3'd3,
    PH_READ_COUNT  = 3'd4,
    PH_READ_STRING = 3'd5,
    PH_READ_CHECK  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_REQ  = 2'd1,
    TAIL_DONE = 2'd2
  } tail_t;

  // One accepted item's worth of results, expanded by the back end.
  typedef struct packed {
    logic            send4;
    logic [3:0][7:0] send_bytes;
    logic            has_reply;
    logic [7:0]      reply_byte;
    tail_t           tail;
    logic            done_status;
  } job_t;

endpackage

// File: hdl/spi_command_ack_transaction_top.sv
// Top level of the SPI command/ACK transaction master: front end, job queue
// and back end. Uses spica_pkg, spica_front, spica_queue, spica_back.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid/in_ready    | command, request bytes, reply_len, flags, rx
//  out_    | output    | out_valid/out_ready  | kind, data_byte, frame_level, status, last
//  cfg_    | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An input item is decoded in the cycle of its transfer; results leave one per cycle
// while out_ready allows, and an item yields up to five results.
// The job queue lets new items transfer while earlier results still drain.
// Reset (rst_n low, synchronous) returns to idle with default timeout and settle values.
// in_ready drops only when the job queue is full; cfg_ready is always high.
module spi_command_ack_transaction_top
  import spica_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_dev_addr,
  input  logic [7:0]           in_op_code,
  input  logic [7:0]           in_param_one,
  input  logic [7:0]           in_param_two,
  input  logic signed [6:0]    in_reply_len,
  input  logic                 in_use_ack,
  input  logic                 in_ack_level,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_data_byte,
  output logic                 out_frame_level,
  output logic                 out_status,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic job_push, q_full, q_pop, q_valid, item_accept;
  job_t front_job, q_job;

  assign in_ready    = !q_full;
  assign cfg_ready   = 1'b1;
  assign item_accept = in_valid && in_ready;

  spica_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_accept (item_accept),
    .command     (in_command),
    .dev_addr    (in_dev_addr),
    .op_code     (in_op_code),
    .param_one   (in_param_one),
    .param_two   (in_param_two),
    .reply_len   (in_reply_len),
    .use_ack     (in_use_ack),
    .ack_level   (in_ack_level),
    .rx_byte     (in_rx_byte),
    .job_push    (job_push),
    .job         (front_job)
  );

  spica_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  spica_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_valid),
    .job_in          (q_job),
    .job_pop         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_frame_level (out_frame_level),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

// File: hdl/spica_front.sv
// Front end: accepts input items, runs the transaction state machine and
// emits one job descriptor per item that produces results. Uses spica_pkg.
module spica_front
  import spica_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 item_accept,
  input  logic [1:0]           command,
  input  logic [7:0]           dev_addr,
  input  logic [7:0]           op_code,
  input  logic [7:0]           param_one,
  input  logic [7:0]           param_two,
  input  logic signed [6:0]    reply_len,
  input  logic                 use_ack,
  input  logic                 ack_level,
  input  logic [7:0]           rx_byte,
  output logic                 job_push,
  output job_t                 job
);

  logic [15:0]      ack_timeout_r, settle_r;
  phase_t           phase_r, phase_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [3:0][7:0]  req_r, req_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ack_mode_r, ack_mode_nxt;
  logic             str_mode_r, str_mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
      settle_r      <= SETTLE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ACK_TIMEOUT) ack_timeout_r <= cfg_data;
      if (cfg_index == CFG_SETTLE)      settle_r      <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      timer_r    <= '0;
      count_r    <= '0;
      sum_r      <= '0;
      req_r      <= '0;
      cnt_r      <= '0;
      ack_mode_r <= 1'b0;
      str_mode_r <= 1'b0;
    end else if (item_accept) begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      req_r      <= req_nxt;
      cnt_r      <= cnt_nxt;
      ack_mode_r <= ack_mode_nxt;
      str_mode_r <= str_mode_nxt;
    end
  end

  logic [6:0]       rl_raw;
  logic [CNT_W-1:0] rl_cnt;
  logic             do_send, do_read, do_finish, fin_status;
  logic [16:0]      timer_inc;
  logic [CNT_W:0]   count_inc;
  logic             ack_ok;

  assign rl_raw    = reply_len;
  assign rl_cnt    = (rl_raw[5:0] > CNT_W'(MAX_REPLY)) ? CNT_W'(MAX_REPLY) : rl_raw[5:0];
  assign timer_inc = {1'b0, timer_r} + 17'd1;
  assign count_inc = {1'b0, count_r} + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    req_nxt      = req_r;
    cnt_nxt      = cnt_r;
    ack_mode_nxt = ack_mode_r;
    str_mode_nxt = str_mode_r;
    do_send      = 1'b0;
    do_read      = 1'b0;
    do_finish    = 1'b0;
    fin_status   = 1'b0;
    ack_ok       = 1'b0;
    job          = '0;
    job.tail     = TAIL_NONE;

    unique case (command)
      CMD_START: begin
        if (phase_r == PH_IDLE) begin
          req_nxt      = {dev_addr, op_code, param_one, param_two};
          ack_mode_nxt = use_ack;
          str_mode_nxt = (rl_raw == 7'h7F);
          cnt_nxt      = (!rl_raw[6] && rl_raw != 7'd0) ? rl_cnt : '0;
          count_nxt    = '0;
          sum_nxt      = '0;
          timer_nxt    = '0;
          if (use_ack) phase_nxt = PH_WAIT_HIGH;
          else         do_send   = 1'b1;
        end
      end
      CMD_TICK: begin
        if (phase_r == PH_WAIT_HIGH || phase_r == PH_WAIT_LOW) begin
          ack_ok = (phase_r == PH_WAIT_HIGH) ? ack_level : !ack_level;
          if (ack_ok) begin
            if (phase_r == PH_WAIT_HIGH) do_send = 1'b1;
            else                         do_read = 1'b1;
          end else if (timer_r >= ack_timeout_r) begin
            do_finish  = 1'b1;
            fin_status = 1'b1;
          end else begin
            timer_nxt = timer_inc[15:0];
          end
        end else if (phase_r == PH_SETTLE) begin
          timer_nxt = timer_inc[15:0];
          if (timer_inc >= {1'b0, settle_r}) do_read = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (phase_r == PH_READ_COUNT) begin
          if (count_r < cnt_r) begin
            job.has_reply  = 1'b1;
            job.reply_byte = rx_byte;
            sum_nxt        = sum_r + rx_byte;
            count_nxt      = count_inc[CNT_W-1:0];
            if (count_inc < {1'b0, cnt_r} || ack_mode_r) job.tail = TAIL_REQ;
            else do_finish = 1'b1;
          end else begin
            do_finish  = 1'b1;
            fin_status = (~rx_byte != sum_r);
          end
        end else if (phase_r == PH_READ_STRING) begin
          if (rx_byte != 8'd0) begin
            job.has_reply  = 1'b1;
            job.reply_byte = rx_byte;
            sum_nxt        = sum_r + rx_byte;
            count_nxt      = count_inc[CNT_W-1:0];
            if (count_inc < (CNT_W+1)'(STRING_LIMIT)) job.tail = TAIL_REQ;
            else do_finish = 1'b1;
          end else if (ack_mode_r) begin
            phase_nxt = PH_READ_CHECK;
            job.tail  = TAIL_REQ;
          end else begin
            do_finish = 1'b1;
          end
        end else if (phase_r == PH_READ_CHECK) begin
          do_finish  = 1'b1;
          fin_status = (~rx_byte != sum_r);
        end
      end
      default: ;
    endcase

    if (do_send) begin
      job.send4      = 1'b1;
      job.send_bytes = {req_nxt[0], req_nxt[1], req_nxt[2], req_nxt[3]};
      if (cnt_nxt == '0 && !str_mode_nxt) begin
        do_finish = 1'b1;
      end else if (ack_mode_nxt) begin
        phase_nxt = PH_WAIT_LOW;
        timer_nxt = '0;
      end else if (settle_r == 16'd0) begin
        do_read = 1'b1;
      end else begin
        phase_nxt = PH_SETTLE;
        timer_nxt = '0;
      end
    end

    if (do_read) begin
      phase_nxt = str_mode_nxt ? PH_READ_STRING : PH_READ_COUNT;
      count_nxt = '0;
      sum_nxt   = '0;
      job.tail  = TAIL_REQ;
    end

    if (do_finish) begin
      phase_nxt        = PH_IDLE;
      timer_nxt        = '0;
      job.tail         = TAIL_DONE;
      job.done_status  = fin_status;
    end
  end

  assign job_push = item_accept && (job.send4 || job.has_reply || job.tail != TAIL_NONE);

  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (timer_r == 16'd0))
    else $error("timer not cleared in idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ_COUNT) |-> (count_r <= cnt_r))
    else $error("reply count overrun");

  a_string_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ_STRING) |-> (count_r < CNT_W'(STRING_LIMIT)))
    else $error("string limit overrun");

endmodule

// File: hdl/spica_queue.sv
// Short job queue between front and back end, register based.
// Uses spica_pkg for the job descriptor type.
module spica_queue
  import spica_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r;
  logic          do_push, do_pop;

  assign full      = (fill_r == CW'(DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      fill_r <= fill_r + 1'b1;
      else if (do_pop && !do_push) fill_r <= fill_r - 1'b1;
    end
  end

endmodule

// File: hdl/spica_back.sv
// Back end: expands queued jobs into result items, one per cycle while the
// output is not stalled, into a registered output stage. Uses spica_pkg.
module spica_back
  import spica_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job_in,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_frame_level,
  output logic       out_status,
  output logic       out_last
);

  logic       wk_valid_r;
  job_t       wk_job_r;
  logic [2:0] wk_pos_r;
  logic [2:0] n_items;
  logic       load_out, is_last, wk_done;

  logic       out_valid_r;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] data_r, data_nxt;
  logic       frame_r, frame_nxt;
  logic       status_r, status_nxt;
  logic       last_r;

  assign n_items = {wk_job_r.send4, 2'b00} + {2'b00, wk_job_r.has_reply}
                 + {2'b00, (wk_job_r.tail != TAIL_NONE)};
  assign is_last  = (wk_pos_r == n_items - 3'd1);
  assign load_out = wk_valid_r && (!out_valid_r || out_ready);
  assign wk_done  = load_out && is_last;
  assign job_pop  = job_valid && (!wk_valid_r || wk_done);

  always_comb begin
    kind_nxt   = KIND_DONE;
    data_nxt   = 8'd0;
    frame_nxt  = 1'b0;
    status_nxt = 1'b0;
    if (wk_job_r.send4 && !wk_pos_r[2]) begin
      kind_nxt  = KIND_SEND;
      data_nxt  = wk_job_r.send_bytes[wk_pos_r[1:0]];
      frame_nxt = 1'b1;
    end else if (wk_job_r.has_reply && wk_pos_r == 3'd0) begin
      kind_nxt  = KIND_REPLY;
      data_nxt  = wk_job_r.reply_byte;
      frame_nxt = 1'b1;
    end else if (wk_job_r.tail == TAIL_REQ) begin
      kind_nxt  = KIND_READ;
      frame_nxt = 1'b1;
    end else begin
      kind_nxt   = KIND_DONE;
      status_nxt = wk_job_r.done_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_valid_r <= 1'b0;
      wk_pos_r   <= '0;
    end else if (job_pop) begin
      wk_valid_r <= 1'b1;
      wk_pos_r   <= '0;
    end else if (wk_done) begin
      wk_valid_r <= 1'b0;
    end else if (load_out) begin
      wk_pos_r <= wk_pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) wk_job_r <= job_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind_r   <= kind_nxt;
      data_r   <= data_nxt;
      frame_r  <= frame_nxt;
      status_r <= status_nxt;
      last_r   <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_data_byte   = data_r;
  assign out_frame_level = frame_r;
  assign out_status      = status_r;
  assign out_last        = last_r;

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    wk_valid_r |-> (n_items != 3'd0))
    else $error("empty job in back end");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wk_valid_r |-> (wk_pos_r < n_items))
    else $error("result index past job end");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (wk_done && !job_valid) |=> !wk_valid_r)
    else $error("job not retired after last result");

endmodule
